[rtl/lbs_pkg.sv]
`default_nettype none

package lbs_pkg;

    localparam int TIME_W  = 40;
    localparam int FIELD_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // service-time register is one bit wider so 1 << fraction bits fits at
    // fraction settings up to 16
    localparam int TPU_W  = FIELD_W + 1;
    localparam int PROD_W = FIELD_W + TPU_W;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_PER_UNIT = 1'd1;

    typedef struct packed {
        logic               cmd;
        logic [TIME_W-1:0]  arrival_time;
        logic [FIELD_W-1:0] packet_id;
        logic [FIELD_W-1:0] packet_length;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]  depart_time;
        logic [FIELD_W-1:0] out_id;
        logic [FIELD_W-1:0] out_length;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] len;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
    } queue_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP,
        ST_FETCH,
        ST_MUL,
        ST_ADD,
        ST_EMIT,
        ST_ENQ
    } state_t;

endpackage

`default_nettype wire

[rtl/lbs_queue.sv]
`default_nettype none

// Circular packet queue; head entry is read through a registered port.
module lbs_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lbs_pkg::queue_ctrl_t ctrl,
    input  wire lbs_pkg::entry_t      wr_entry,
    output lbs_pkg::entry_t           rd_entry,
    output lbs_pkg::queue_stat_t      stat
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    lbs_pkg::entry_t mem [QUEUE_DEPTH];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    lbs_pkg::entry_t  rd_entry_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop) begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
        if (ctrl.push) begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[tail_reg] <= wr_entry;
        end
        rd_entry_reg <= mem[head_reg];
    end

    assign rd_entry   = rd_entry_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.one   = (count_reg == CNT_W'(1));
    assign stat.full  = (count_reg == FULL_CNT);

endmodule

`default_nettype wire

[rtl/leaky_bucket_packet_shaper_top.sv]
// Leaky-bucket packet shaper.
// Input channel s_valid/s_ready/s_data carries one item: an arrival (cmd 0)
// with time, id and length, or a flush (cmd 1). Result channel
// m_valid/m_ready/m_data carries one item per departing packet, oldest
// first, stamped with its departure time; last marks the final departure
// caused by an input item. An item that releases nothing gives no result.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata writes max_length (index 0)
// or time_per_unit (index 1); write only while the block is idle.
// Timing: one item at a time, s_ready is high only when the sequencer idles.
// An item with no release is accepted and checked, then ends when dropped
// or an empty flush, is enqueued when only queued, and when the clock
// restarts passes through multiply and add on the shared 16x17 multiplier
// and 41-bit saturating adder before its enqueue. Each release steps
// through at most pop, head read from the queue's registered port,
// multiply, add/compare, and output register load; a flush's final release
// is only pop and load. A stalled receiver holds the output register and
// the sequencer waits in its emit step; nothing is lost.
// Reset (aresetn low, synchronous) empties the queue, zeroes the clock,
// sets max_length to 65535 and time_per_unit to 1.0; no clearing pass.
`default_nettype none

module leaky_bucket_packet_shaper_top #(
    parameter int QUEUE_DEPTH        = 16,
    parameter int TIME_FRACTION_BITS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire lbs_pkg::in_item_t                  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output lbs_pkg::out_item_t                      m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [lbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int TIME_W  = lbs_pkg::TIME_W;
    localparam int FIELD_W = lbs_pkg::FIELD_W;
    localparam int TPU_W   = lbs_pkg::TPU_W;
    localparam int PROD_W  = lbs_pkg::PROD_W;
    localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(1) << TIME_FRACTION_BITS;

    lbs_pkg::state_t      state_reg, state_next;
    lbs_pkg::in_item_t    item_reg;
    lbs_pkg::entry_t      ent_reg;
    lbs_pkg::entry_t      head_entry;
    lbs_pkg::entry_t      wr_entry;
    lbs_pkg::queue_ctrl_t q_ctrl;
    lbs_pkg::queue_stat_t q_stat;
    lbs_pkg::out_item_t   m_data_reg;

    logic [TIME_W-1:0]  ct_reg;      // next completion time
    logic [TIME_W-1:0]  dep_reg;     // departure stamp of the popped packet
    logic [PROD_W-1:0]  prod_reg;
    logic               arr_op_reg;  // multiply/add uses the arriving packet
    logic               last_reg;
    logic               pend_reg;    // a popped packet still waits to go out
    logic               m_valid_reg;
    logic [FIELD_W-1:0] max_len_reg;
    logic [TPU_W-1:0]   tpu_reg;

    logic               is_flush;
    logic               too_long;
    logic               ct_late;
    logic               out_free;
    logic               out_load;
    logic [FIELD_W-1:0] mul_a;
    logic [TIME_W-1:0]  add_a;
    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  sum_sat;

    lbs_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .wr_entry(wr_entry),
        .rd_entry(head_entry),
        .stat    (q_stat)
    );

    assign is_flush = (item_reg.cmd == lbs_pkg::CMD_FLUSH);
    assign too_long = (item_reg.packet_length > max_len_reg);
    assign ct_late  = (ct_reg > item_reg.arrival_time);
    assign out_free = !m_valid_reg || m_ready;

    // shared multiplier and saturating adder
    assign mul_a   = arr_op_reg ? item_reg.packet_length : head_entry.len;
    assign add_a   = arr_op_reg ? item_reg.arrival_time : ct_reg;
    assign sum     = {1'b0, add_a} + (TIME_W + 1)'(prod_reg);
    assign sum_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    assign wr_entry.id  = item_reg.packet_id;
    assign wr_entry.len = item_reg.packet_length;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lbs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lbs_pkg::ST_CHECK;
                end
            end
            lbs_pkg::ST_CHECK: begin
                if (is_flush) begin
                    state_next = q_stat.empty ? lbs_pkg::ST_IDLE : lbs_pkg::ST_POP;
                end else if (too_long) begin
                    state_next = lbs_pkg::ST_IDLE;
                end else if (ct_late) begin
                    state_next = lbs_pkg::ST_ENQ;
                end else if (q_stat.empty) begin
                    state_next = lbs_pkg::ST_MUL;
                end else begin
                    state_next = lbs_pkg::ST_POP;
                end
            end
            lbs_pkg::ST_POP: begin
                if (!q_stat.one) begin
                    state_next = lbs_pkg::ST_FETCH;
                end else if (is_flush) begin
                    state_next = lbs_pkg::ST_EMIT;
                end else begin
                    state_next = lbs_pkg::ST_MUL;
                end
            end
            lbs_pkg::ST_FETCH: begin
                state_next = lbs_pkg::ST_MUL;
            end
            lbs_pkg::ST_MUL: begin
                state_next = lbs_pkg::ST_ADD;
            end
            lbs_pkg::ST_ADD: begin
                if (arr_op_reg && !pend_reg) begin
                    state_next = lbs_pkg::ST_ENQ;
                end else begin
                    state_next = lbs_pkg::ST_EMIT;
                end
            end
            lbs_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (!last_reg) begin
                        state_next = lbs_pkg::ST_POP;
                    end else if (is_flush) begin
                        state_next = lbs_pkg::ST_IDLE;
                    end else begin
                        state_next = lbs_pkg::ST_ENQ;
                    end
                end
            end
            lbs_pkg::ST_ENQ: begin
                state_next = lbs_pkg::ST_IDLE;
            end
            default: begin
                state_next = lbs_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready     = (state_reg == lbs_pkg::ST_IDLE);
        q_ctrl.pop  = (state_reg == lbs_pkg::ST_POP);
        q_ctrl.push = (state_reg == lbs_pkg::ST_ENQ) && !q_stat.full;
        out_load    = (state_reg == lbs_pkg::ST_EMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lbs_pkg::ST_IDLE;
            ct_reg      <= '0;
            arr_op_reg  <= 1'b0;
            last_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            max_len_reg <= {FIELD_W{1'b1}};
            tpu_reg     <= TPU_RESET;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                if (cfg_index == lbs_pkg::REG_MAX_LENGTH) begin
                    max_len_reg <= cfg_wdata;
                end else if (cfg_index == lbs_pkg::REG_TIME_PER_UNIT) begin
                    tpu_reg <= TPU_W'(cfg_wdata);
                end
            end

            unique case (state_reg)
                lbs_pkg::ST_CHECK: begin
                    arr_op_reg <= 1'b1;
                    pend_reg   <= 1'b0;
                end
                lbs_pkg::ST_POP: begin
                    pend_reg   <= 1'b1;
                    arr_op_reg <= q_stat.one;
                    last_reg   <= q_stat.one;
                end
                lbs_pkg::ST_ADD: begin
                    ct_reg <= sum_sat;
                    if (!arr_op_reg) begin
                        last_reg <= !is_flush && (sum_sat > item_reg.arrival_time);
                    end
                end
                default: begin
                end
            endcase

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (q_ctrl.pop) begin
            dep_reg <= ct_reg;
            ent_reg <= head_entry;
        end
        if (state_reg == lbs_pkg::ST_MUL) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(tpu_reg);
        end
        if (out_load) begin
            m_data_reg.depart_time <= dep_reg;
            m_data_reg.out_id      <= ent_reg.id;
            m_data_reg.out_length  <= ent_reg.len;
            m_data_reg.last        <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/lbs_checker.sv]
`default_nettype none

module lbs_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire lbs_pkg::out_item_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    // more departures pending for the current item
    a_busy_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("ready before last departure");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind leaky_bucket_packet_shaper_top lbs_checker u_lbs_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire
